// ===== sv/clpm_pkg.sv =====
// clpm_pkg: shared types and constants of the prefix match table
// depends on nothing; used by the channel interfaces and the top level

package clpm_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned LEN_W   = 8;
  localparam int unsigned GROUP_W = 5;
  localparam int unsigned ST_W    = 2;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
  localparam logic [ST_W-1:0] ST_TOO_LONG = 2'd2;

  localparam logic [LEN_W-1:0]  V4_MAX_LEN = 8'd32;
  localparam logic [LEN_W-1:0]  V6_MAX_LEN = 8'd128;
  localparam logic [LEN_W-1:0]  HALF_LEN   = 8'd64;
  localparam logic [ADDR_W-1:0] V4_HI_MASK = 64'hFFFF_FFFF_0000_0000;

  typedef struct packed {
    logic              is_v6;
    logic [ADDR_W-1:0] addr_hi;
    logic [ADDR_W-1:0] addr_lo;
    logic [LEN_W-1:0]  prefix;
    logic [GROUP_W-1:0] group;
  } entry_t;

endpackage

// ===== sv/clpm_if.sv =====
// clpm_in_if and clpm_out_if: valid/ready channels of the prefix match table
// depends on clpm_pkg for field widths

interface clpm_in_if;
  logic                              valid;
  logic                              ready;
  logic [clpm_pkg::OP_W-1:0]         operation;
  logic                              family;
  logic [clpm_pkg::ADDR_W-1:0]       addr_hi;
  logic [clpm_pkg::ADDR_W-1:0]       addr_lo;
  logic [clpm_pkg::LEN_W-1:0]        prefix_len;
  logic [clpm_pkg::GROUP_W-1:0]      group_id;

  modport source (output valid, operation, family, addr_hi, addr_lo, prefix_len, group_id,
                  input ready);
  modport sink (input valid, operation, family, addr_hi, addr_lo, prefix_len, group_id,
                output ready);
endinterface

interface clpm_out_if;
  logic                              valid;
  logic                              ready;
  logic [clpm_pkg::ST_W-1:0]         status;
  logic                              found;
  logic [clpm_pkg::GROUP_W-1:0]      match_group;
  logic [clpm_pkg::LEN_W-1:0]        match_len;

  modport source (output valid, status, found, match_group, match_len, input ready);
  modport sink (input valid, status, found, match_group, match_len, output ready);
endinterface

// ===== sv/cidr_longest_prefix_match.sv =====
// cidr_longest_prefix_match: ipv4/ipv6 prefix table with longest prefix lookup
// depends on clpm_pkg and the channel interfaces in clpm_if.sv
//
// usage:
//   in_ch carries one request item: insert, lookup or clear. out_ch returns
//   exactly one result item per request, in order.
//   insert appends an entry at the fill count and writes the table memory in
//   the accept cycle; its result passes through the done state.
//   clear zeroes the fill count; its result also passes through the done state.
//   lookup reads the table memory one entry per cycle over the n stored
//   entries (one read port, registered read data), compares each against
//   the key and keeps the longest, earliest match; its result passes
//   through the scan, drain and done states (done alone on an empty table).
//   one request is worked on at a time; in_ch.ready is high while no
//   request is in progress, and the next request is accepted while a
//   finished result still waits in the output register.
//   when out_ch stalls, the result holds and a finished request waits in
//   its done state until the output register frees.
//   reset empties the table (fill count zero) and drops any pending result;
//   entry memory contents are not cleared.

module cidr_longest_prefix_match #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  clpm_in_if.sink          in_ch,
  clpm_out_if.source       out_ch
);

  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_DONE} state_t;

  state_t                           state_r;
  logic [CNT_W-1:0]                 cnt_r;
  logic [IDX_W-1:0]                 rd_idx_r;
  logic                             rd_vld_r;
  clpm_pkg::entry_t                 rd_data_r;
  clpm_pkg::entry_t                 mem [TABLE_ENTRIES];

  logic                             key_fam_r;
  logic [clpm_pkg::ADDR_W-1:0]      key_hi_r;
  logic [clpm_pkg::ADDR_W-1:0]      key_lo_r;

  logic [clpm_pkg::ST_W-1:0]        res_status_r;
  logic                             best_found_r;
  logic [clpm_pkg::GROUP_W-1:0]     best_group_r;
  logic [clpm_pkg::LEN_W-1:0]       best_len_r;

  logic                             out_valid_r;
  logic [clpm_pkg::ST_W-1:0]        out_status_r;
  logic                             out_found_r;
  logic [clpm_pkg::GROUP_W-1:0]     out_group_r;
  logic [clpm_pkg::LEN_W-1:0]       out_len_r;

  logic                             in_acc;
  logic                             full;
  logic                             too_long;
  logic                             ins_ok;
  logic                             rd_en;
  logic [IDX_W-1:0]                 last_idx;
  logic [CNT_W-1:0]                 cnt_dec;
  clpm_pkg::entry_t                 wr_data;
  logic [clpm_pkg::ADDR_W-1:0]      mask_hi;
  logic [clpm_pkg::ADDR_W-1:0]      mask_lo;
  logic [clpm_pkg::LEN_W-1:0]       lo_len;
  logic                             hit;
  logic                             take;
  logic                             out_free;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign full        = (cnt_r >= CNT_W'(TABLE_ENTRIES));
  assign too_long    = in_ch.family ? (in_ch.prefix_len > clpm_pkg::V6_MAX_LEN)
                                    : (in_ch.prefix_len > clpm_pkg::V4_MAX_LEN);
  assign ins_ok      = in_acc && (in_ch.operation == clpm_pkg::OP_INSERT) && !full && !too_long;
  assign cnt_dec     = cnt_r - CNT_W'(1);
  assign last_idx    = cnt_dec[IDX_W-1:0];
  assign rd_en       = (state_r == S_SCAN);
  assign out_free    = !out_valid_r || out_ch.ready;

  always_comb begin
    wr_data.is_v6   = in_ch.family;
    wr_data.addr_hi = in_ch.family ? in_ch.addr_hi : (in_ch.addr_hi & clpm_pkg::V4_HI_MASK);
    wr_data.addr_lo = in_ch.family ? in_ch.addr_lo : '0;
    wr_data.prefix  = in_ch.prefix_len;
    wr_data.group   = in_ch.group_id;
  end

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ins_ok) begin
      mem[cnt_r[IDX_W-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx_r];
    end
  end

  // prefix compare of the entry read last cycle
  always_comb begin
    lo_len  = (rd_data_r.prefix > clpm_pkg::HALF_LEN) ? (rd_data_r.prefix - clpm_pkg::HALF_LEN)
                                                      : '0;
    mask_hi = ~({clpm_pkg::ADDR_W{1'b1}} >> rd_data_r.prefix);
    mask_lo = ~({clpm_pkg::ADDR_W{1'b1}} >> lo_len);
    hit     = (rd_data_r.is_v6 == key_fam_r)
              && (((rd_data_r.addr_hi ^ key_hi_r) & mask_hi) == '0)
              && (((rd_data_r.addr_lo ^ key_lo_r) & mask_lo) == '0);
    take    = rd_vld_r && hit && (!best_found_r || (rd_data_r.prefix > best_len_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      rd_idx_r    <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (take) begin
        best_found_r <= 1'b1;
        best_len_r   <= rd_data_r.prefix;
        best_group_r <= rd_data_r.group;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            res_status_r <= clpm_pkg::ST_OK;
            best_found_r <= 1'b0;
            best_group_r <= '0;
            best_len_r   <= '0;
            key_fam_r    <= in_ch.family;
            key_hi_r     <= in_ch.addr_hi;
            key_lo_r     <= in_ch.addr_lo;
            rd_idx_r     <= '0;
            state_r      <= S_DONE;
            unique case (in_ch.operation)
              clpm_pkg::OP_INSERT: begin
                if (full) begin
                  res_status_r <= clpm_pkg::ST_FULL;
                end else if (too_long) begin
                  res_status_r <= clpm_pkg::ST_TOO_LONG;
                end else begin
                  cnt_r <= cnt_r + CNT_W'(1);
                end
              end
              clpm_pkg::OP_LOOKUP: begin
                if (cnt_r != '0) begin
                  state_r <= S_SCAN;
                end
              end
              clpm_pkg::OP_CLEAR: begin
                cnt_r <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          if (rd_idx_r == last_idx) begin
            state_r <= S_DRAIN;
          end else begin
            rd_idx_r <= rd_idx_r + IDX_W'(1);
          end
        end
        S_DRAIN: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_status_r <= res_status_r;
            out_found_r  <= best_found_r;
            out_group_r  <= best_group_r;
            out_len_r    <= best_len_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.match_group = out_group_r;
  assign out_ch.match_len   = out_len_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TABLE_ENTRIES))
    else $error("fill count beyond table size");

  a_rd_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == S_SCAN || state_r == S_DRAIN))
    else $error("read data valid outside a scan");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    ins_ok |=> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("accepted insert did not advance fill count");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside done state");

  a_best_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && best_found_r) |-> (best_len_r <= clpm_pkg::V6_MAX_LEN))
    else $error("winning prefix length out of range");

endmodule
